/* sv/pbaf_pkg.sv */
// Package for the protobuf audio frame parser: widths, phase codes and helpers.
// No dependencies; used by every module of the block.
`default_nettype none
package pbaf_pkg;
  localparam int unsigned MaxFrameBytes = 65536;
  localparam int PosW = $clog2(MaxFrameBytes + 1);
  localparam int FnW = 29;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_AUDIO_FRAME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERRUPT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_AUDIO_BYTES = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RATE        = 2'd3;

  typedef enum logic [3:0] {
    PH_OTAG, PH_OVAL, PH_OLEN, PH_OSKIP, PH_ITAG, PH_IVAL, PH_ILEN, PH_ISKIP, PH_ERR
  } phase_t;

  typedef struct packed {
    logic [FnW-1:0] audio_frame;
    logic [FnW-1:0] interrupt;
    logic [FnW-1:0] audio_bytes;
    logic [FnW-1:0] rate;
  } cfg_t;

  typedef struct packed {
    logic        status;
    logic        audio_found;
    logic [15:0] audio_offset;
    logic [16:0] audio_length;
    logic [31:0] rate_word;
    logic        interrupted;
  } result_t;
endpackage
`default_nettype wire

/* sv/pbaf_cfg_regs.sv */
// Configuration register file for the parser's four field numbers.
// Depends on pbaf_pkg.
`default_nettype none
module pbaf_cfg_regs import pbaf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [FnW-1:0]     cfg_wdata,
  output cfg_t                    cfg
);
  cfg_t cfg_r;
  assign cfg = cfg_r;

  // Write one register per request; reset restores the default numbers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.audio_frame <= FnW'(2);
      cfg_r.interrupt   <= FnW'(5);
      cfg_r.audio_bytes <= FnW'(3);
      cfg_r.rate        <= FnW'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AUDIO_FRAME: cfg_r.audio_frame <= cfg_wdata;
        CFG_INTERRUPT:   cfg_r.interrupt   <= cfg_wdata;
        CFG_AUDIO_BYTES: cfg_r.audio_bytes <= cfg_wdata;
        CFG_RATE:        cfg_r.rate        <= cfg_wdata;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/pbaf_parser.sv */
// Byte-wide wire-format parser state and its next-state logic.
// Depends on pbaf_pkg; emits one result on the last byte of each frame.
`default_nettype none
module pbaf_parser import pbaf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       byte_en,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output result_t         res
);
  phase_t          phase_r, phase_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [FnW-1:0]  fn_r, fn_nxt;
  logic            wide_r, wide_nxt;
  logic [PosW-1:0] orem_r, orem_nxt, irem_r, irem_nxt, pos_r, pos_nxt;
  logic [31:0]     rate_r, rate_nxt;
  logic [15:0]     off_r, off_nxt;
  logic [16:0]     len_r, len_nxt;
  logic [2:0]      seen_r, seen_nxt;

  logic [63:0] full, part;
  logic        done, ovl, inner, bad, len_big;
  logic [PosW-1:0] v, omax;
  phase_t      ph;

  // Combine this byte into the varint and decode the outcome.
  always_comb begin
    part = 64'(data_byte[6:0]) << (7 * cnt_r);
    full = acc_r | part;
    done = !data_byte[7];
    ovl  = data_byte[7] && (cnt_r == 4'd9);
    len_big = |full[63:PosW];
    v = full[PosW-1:0];
    omax = PosW'(MaxFrameBytes - 1) - pos_r;
  end

  always_comb begin
    phase_nxt = phase_r; acc_nxt = acc_r; cnt_nxt = cnt_r;
    fn_nxt = fn_r; wide_nxt = wide_r; orem_nxt = orem_r; irem_nxt = irem_r;
    pos_nxt = pos_r; rate_nxt = rate_r; off_nxt = off_r; len_nxt = len_r;
    seen_nxt = seen_r;
    ph = (pos_r >= PosW'(MaxFrameBytes)) ? PH_ERR : phase_r;
    inner = (ph == PH_ITAG) || (ph == PH_IVAL) || (ph == PH_ILEN) || (ph == PH_ISKIP);
    if (inner) orem_nxt = orem_r - 1'b1;
    // Varint phases share the accumulator.
    if (ph == PH_OTAG || ph == PH_ITAG || ph == PH_OVAL || ph == PH_OLEN ||
        ph == PH_IVAL || ph == PH_ILEN) begin
      if (done) begin
        acc_nxt = '0; cnt_nxt = '0;
      end else begin
        acc_nxt = full; cnt_nxt = cnt_r + 1'b1;
      end
    end
    case (ph)
      PH_OTAG, PH_ITAG: begin
        if (ovl) phase_nxt = PH_ERR;
        else if (done) begin
          fn_nxt = full[FnW+2:3];
          wide_nxt = |full[63:32];
          case (full[2:0])
            3'd0: phase_nxt = inner ? PH_IVAL : PH_OVAL;
            3'd2: phase_nxt = inner ? PH_ILEN : PH_OLEN;
            3'd1, 3'd5: begin
              if (inner) begin
                if ((full[2] ? PosW'(4) : PosW'(8)) > orem_nxt) phase_nxt = PH_ERR;
                else begin
                  irem_nxt = full[2] ? PosW'(4) : PosW'(8); phase_nxt = PH_ISKIP;
                end
              end else begin
                orem_nxt = full[2] ? PosW'(4) : PosW'(8); phase_nxt = PH_OSKIP;
              end
            end
            default: phase_nxt = PH_ERR;
          endcase
        end
      end
      PH_OVAL: begin
        if (ovl) phase_nxt = PH_ERR;
        else if (done) phase_nxt = PH_OTAG;
      end
      PH_OSKIP: begin
        orem_nxt = orem_r - 1'b1;
        if (orem_r == PosW'(1)) phase_nxt = PH_OTAG;
      end
      PH_OLEN: begin
        if (ovl) phase_nxt = PH_ERR;
        else if (done) begin
          if (len_big || v > omax) phase_nxt = PH_ERR;
          else begin
            orem_nxt = v;
            if (!wide_r && fn_r == cfg.audio_frame)
              phase_nxt = (v != '0) ? PH_ITAG : PH_OTAG;
            else begin
              if (!wide_r && fn_r == cfg.interrupt) seen_nxt[1] = 1'b1;
              phase_nxt = (v != '0) ? PH_OSKIP : PH_OTAG;
            end
          end
        end
      end
      PH_IVAL: begin
        if (ovl) phase_nxt = PH_ERR;
        else if (done) begin
          if (!wide_r && fn_r == cfg.rate) begin
            rate_nxt = full[31:0]; seen_nxt[2] = 1'b1;
          end
          phase_nxt = PH_ITAG;
        end
      end
      PH_ILEN: begin
        if (ovl) phase_nxt = PH_ERR;
        else if (done) begin
          if (len_big || v > orem_nxt) phase_nxt = PH_ERR;
          else begin
            if (!wide_r && fn_r == cfg.audio_bytes) begin
              seen_nxt[0] = 1'b1;
              off_nxt = 16'(pos_r + 1'b1);
              len_nxt = 17'(v);
            end
            irem_nxt = v;
            phase_nxt = (v != '0) ? PH_ISKIP : PH_ITAG;
          end
        end
      end
      PH_ISKIP: begin
        irem_nxt = irem_r - 1'b1;
        if (irem_r == PosW'(1)) phase_nxt = PH_ITAG;
      end
      default: phase_nxt = PH_ERR;
    endcase
    // Leaving the nested message when its length runs out.
    if (inner && phase_nxt != PH_ERR && orem_nxt == '0) begin
      if (phase_nxt == PH_ITAG && cnt_nxt == '0) phase_nxt = PH_OTAG;
      else phase_nxt = PH_ERR;
    end
    if (pos_r < PosW'(MaxFrameBytes)) pos_nxt = pos_r + 1'b1;
    bad = (phase_nxt != PH_OTAG) || (cnt_nxt != '0);
  end

  // Parser state; cleared by reset and after each frame's last byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last_byte)) begin
      phase_r <= PH_OTAG; acc_r <= '0; cnt_r <= '0; fn_r <= '0; wide_r <= 1'b0;
      orem_r <= '0; irem_r <= '0; pos_r <= '0; rate_r <= '0; off_r <= '0;
      len_r <= '0; seen_r <= '0;
    end else if (byte_en) begin
      phase_r <= phase_nxt; acc_r <= acc_nxt; cnt_r <= cnt_nxt; fn_r <= fn_nxt;
      wide_r <= wide_nxt; orem_r <= orem_nxt; irem_r <= irem_nxt; pos_r <= pos_nxt;
      rate_r <= rate_nxt; off_r <= off_nxt; len_r <= len_nxt; seen_r <= seen_nxt;
    end
  end

  // Result of the frame as it stands after this byte.
  always_comb begin
    res.status       = bad;
    res.audio_found  = !bad && seen_nxt[0];
    res.audio_offset = bad ? '0 : off_nxt;
    res.audio_length = bad ? '0 : len_nxt;
    res.rate_word    = bad ? '0 : rate_nxt;
    res.interrupted  = !bad && seen_nxt[1];
  end
endmodule
`default_nettype wire

/* sv/protobuf_audio_frame_parser_top.sv */
// Top level of the protobuf audio frame parser: input register, parser, result register.
// Depends on pbaf_pkg, pbaf_cfg_regs and pbaf_parser.
//
//  channel | ports                      | contents
//  in      | in_tvalid/tready/tdata/tlast | tdata = data_byte, tlast = last_byte
//  out     | out_tvalid/tready/tdata    | one result per frame
//  cfg     | cfg_we/cfg_index/cfg_wdata | four field-number registers
//
// One byte per cycle unless the input stalls; a byte waits in the input register, and
// its frame result is written to the result register as it leaves. Reset is synchronous.
// The input stalls only when the result register is full, not taken, and the byte in
// the input register ends a frame.
`default_nettype none
module protobuf_audio_frame_parser_top import pbaf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] data_byte
  input  wire logic               in_tlast,   // last_byte
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [0] status, [1] audio found, [17:2] audio_offset, [34:18] audio_length,
  // [66:35] sample rate, [67] interrupted, [71:68] zero
  output logic [71:0]             out_tdata,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [FnW-1:0]     cfg_wdata
);
  cfg_t        cfg;
  result_t     res;
  logic        iv_r;
  logic [7:0]  ib_r;
  logic        il_r;
  logic        ov_r;
  logic [71:0] od_r;
  logic        stage_go;

  pbaf_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .cfg
  );

  // The held byte moves on unless it would produce a result that has nowhere to go.
  assign stage_go  = iv_r && !(il_r && ov_r && !out_tready);
  assign in_tready = !iv_r || stage_go;

  pbaf_parser u_parser (
    .clk, .rst_n, .cfg, .byte_en(stage_go), .data_byte(ib_r), .last_byte(il_r), .res
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_tready) begin
      iv_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      ib_r <= in_tdata;
      il_r <= in_tlast;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (stage_go && il_r) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (stage_go && il_r) begin
      od_r <= {4'd0, res.interrupted, res.rate_word, res.audio_length,
               res.audio_offset, res.audio_found, res.status};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule
`default_nettype wire

/* sim/tb_protobuf_audio_frame_parser_top.sv */
// Testbench for protobuf_audio_frame_parser_top: streams encoded messages and
// checks every frame result against a cycle-free decoder kept in a scoreboard class.
// Depends on pbaf_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_protobuf_audio_frame_parser_top;
  import pbaf_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam logic [FnW-1:0] FnMax = 29'h1FFF_FFFF;

  // Wire types of the protobuf encoding.
  localparam int WtVarint = 0;
  localparam int WtFixed64 = 1;
  localparam int WtLen = 2;
  localparam int WtFixed32 = 5;

  // Frame decoder and store of expected frame results.
  class frame_scoreboard;
    logic [FnW-1:0] af, intf, ab, rf;
    phase_t ph;
    longint unsigned acc;
    int unsigned cnt, orem, irem, pos;
    logic [FnW-1:0] fnum;
    bit wide;
    logic [31:0] rate;
    logic [15:0] off;
    logic [16:0] alen;
    bit [2:0] seen;
    result_t due[$];
    int errors;

    function new();
      af = 2;
      intf = 5;
      ab = 3;
      rf = 4;
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_OTAG;
      acc = 0;
      cnt = 0;
      fnum = 0;
      wide = 0;
      orem = 0;
      irem = 0;
      pos = 0;
      rate = 0;
      off = 0;
      alen = 0;
      seen = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [FnW-1:0] val);
      case (idx)
        CFG_AUDIO_FRAME: af = val;
        CFG_INTERRUPT: intf = val;
        CFG_AUDIO_BYTES: ab = val;
        default: rf = val;
      endcase
    endfunction

    // Returns 1 when the varint is complete, 0 when more bytes follow, -1 if overlong.
    function int feed(bit [7:0] b, output longint unsigned v);
      acc |= longint'(b[6:0]) << (7 * cnt);
      v = acc;
      if (!b[7]) begin
        acc = 0;
        cnt = 0;
        return 1;
      end
      cnt++;
      return (cnt >= 10) ? -1 : 0;
    endfunction

    function bit is_fld(logic [FnW-1:0] c);
      return !wide && fnum == c;
    endfunction

    function void inner_fixed(int unsigned n);
      if (n > orem) begin
        ph = PH_ERR;
      end else begin
        irem = n;
        ph = PH_ISKIP;
      end
    endfunction

    function void eat(bit [7:0] b);
      int unsigned p;
      longint unsigned v;
      int r;
      bit inner;
      p = pos;
      v = 0;
      if (p >= MaxFrameBytes) ph = PH_ERR;
      inner = ph >= PH_ITAG && ph <= PH_ISKIP;
      if (inner) orem--;
      case (ph)
        PH_OTAG, PH_ITAG: begin
          r = feed(b, v);
          if (r < 0) begin
            ph = PH_ERR;
          end else if (r > 0) begin
            fnum = v[31:3];
            wide = (v >> 32) != 0;
            case (v[2:0])
              3'd0: ph = inner ? PH_IVAL : PH_OVAL;
              3'd2: ph = inner ? PH_ILEN : PH_OLEN;
              3'd1, 3'd5: begin
                if (inner) begin
                  inner_fixed(v[2:0] == 3'd1 ? 8 : 4);
                end else begin
                  orem = (v[2:0] == 3'd1) ? 8 : 4;
                  ph = PH_OSKIP;
                end
              end
              default: ph = PH_ERR;
            endcase
          end
        end
        PH_OVAL: begin
          r = feed(b, v);
          if (r < 0) ph = PH_ERR;
          else if (r > 0) ph = PH_OTAG;
        end
        PH_OSKIP: begin
          orem--;
          if (orem == 0) ph = PH_OTAG;
        end
        PH_OLEN: begin
          r = feed(b, v);
          if (r < 0) begin
            ph = PH_ERR;
          end else if (r > 0) begin
            if (v > longint'(MaxFrameBytes - 1 - p)) begin
              ph = PH_ERR;
            end else begin
              orem = v[31:0];
              if (is_fld(af)) begin
                ph = (v != 0) ? PH_ITAG : PH_OTAG;
              end else begin
                if (is_fld(intf)) seen[1] = 1;
                ph = (v != 0) ? PH_OSKIP : PH_OTAG;
              end
            end
          end
        end
        PH_IVAL: begin
          r = feed(b, v);
          if (r < 0) begin
            ph = PH_ERR;
          end else if (r > 0) begin
            if (is_fld(rf)) begin
              rate = v[31:0];
              seen[2] = 1;
            end
            ph = PH_ITAG;
          end
        end
        PH_ILEN: begin
          r = feed(b, v);
          if (r < 0) begin
            ph = PH_ERR;
          end else if (r > 0) begin
            if (v > orem) begin
              ph = PH_ERR;
            end else begin
              if (is_fld(ab)) begin
                seen[0] = 1;
                off = 16'(p + 1);
                alen = v[16:0];
              end
              irem = v[31:0];
              ph = (v != 0) ? PH_ISKIP : PH_ITAG;
            end
          end
        end
        PH_ISKIP: begin
          irem--;
          if (irem == 0) ph = PH_ITAG;
        end
        default: ph = PH_ERR;
      endcase
      // The nested message must end exactly on a field boundary.
      if (inner && ph != PH_ERR && orem == 0) begin
        if (ph == PH_ITAG && cnt == 0) ph = PH_OTAG;
        else ph = PH_ERR;
      end
      if (pos < MaxFrameBytes) pos++;
    endfunction

    // Notes one accepted request of the input channel.
    function void note_byte(bit [7:0] b, bit last);
      result_t e;
      bit bad;
      eat(b);
      if (!last) return;
      bad = ph != PH_OTAG || cnt != 0;
      e = '0;
      e.status = bad;
      if (!bad) begin
        e.audio_found = seen[0];
        e.audio_offset = off;
        e.audio_length = alen;
        e.rate_word = rate;
        e.interrupted = seen[1];
      end
      due.push_back(e);
      clear();
    endfunction

    // Checks one accepted result request.
    function void check_result(logic [71:0] d);
      result_t e;
      bit ok;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = due.pop_front();
      ok = d[0] === e.status && d[1] === e.audio_found && d[17:2] === e.audio_offset
        && d[34:18] === e.audio_length && d[66:35] === e.rate_word
        && d[67] === e.interrupted;
      if (!ok) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected st=%0d aud=%0d off=%0d len=%0d rate=%h int=%0d",
            e.status, e.audio_found, e.audio_offset, e.audio_length, e.rate_word,
            e.interrupted);
          $display("          actual   st=%0d aud=%0d off=%0d len=%0d rate=%h int=%0d",
            d[0], d[1], d[17:2], d[34:18], d[66:35], d[67]);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [71:0] out_tdata;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = CFG_AUDIO_FRAME;
  logic [FnW-1:0] cfg_wdata = 0;

  frame_scoreboard sb = new();
  bit idle_on = 1;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  bit [7:0] msg[$];

  protobuf_audio_frame_parser_top dut (.*);

  always #4 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Handshake monitors feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    out_tready <= !(idle_on && $urandom_range(0, 99) < 12);
  end

  function automatic void put_varint(ref bit [7:0] q[$], input longint unsigned v);
    while (v > 127) begin
      q.push_back({1'b1, v[6:0]});
      v >>= 7;
    end
    q.push_back({1'b0, v[6:0]});
  endfunction

  function automatic void put_tag(ref bit [7:0] q[$], input longint unsigned fn, input int wt);
    put_varint(q, (fn << 3) | wt);
  endfunction

  function automatic longint unsigned rand_wide();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic logic [FnW-1:0] rand_fn();
    if ($urandom_range(0, 1)) return FnW'($urandom_range(1, 20));
    return FnW'($urandom_range(1, FnMax));
  endfunction

  // A field of random number and wire type with matching content.
  function automatic void put_other(ref bit [7:0] q[$]);
    int n;
    case ($urandom_range(0, 3))
      0: begin
        put_tag(q, rand_fn(), WtVarint);
        put_varint(q, rand_wide());
      end
      1: begin
        put_tag(q, rand_fn(), WtFixed64);
        repeat (8) q.push_back(8'($urandom));
      end
      2: begin
        put_tag(q, rand_fn(), WtFixed32);
        repeat (4) q.push_back(8'($urandom));
      end
      default: begin
        n = $urandom_range(0, 6);
        put_tag(q, rand_fn(), WtLen);
        put_varint(q, n);
        repeat (n) q.push_back(8'($urandom));
      end
    endcase
  endfunction

  // Random well-formed message under the current register values.
  function automatic void build_frame(ref bit [7:0] q[$]);
    bit [7:0] sub[$];
    int n;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          sub = {};
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0, 1: begin
                n = $urandom_range(0, 8);
                put_tag(sub, sb.ab, WtLen);
                put_varint(sub, n);
                repeat (n) sub.push_back(8'($urandom));
              end
              2: begin
                put_tag(sub, sb.rf, WtVarint);
                put_varint(sub, rand_wide());
              end
              default: put_other(sub);
            endcase
          end
          put_tag(q, sb.af, WtLen);
          put_varint(q, sub.size());
          q = {q, sub};
        end
        3: begin
          n = $urandom_range(0, 3);
          put_tag(q, sb.intf, WtLen);
          put_varint(q, n);
          repeat (n) q.push_back(8'($urandom));
        end
        4: begin
          put_tag(q, sb.intf, WtVarint);
          put_varint(q, rand_wide());
        end
        default: put_other(q);
      endcase
    end
  endfunction

  // Damages a message in one of several ways.
  function automatic void break_frame(ref bit [7:0] q[$]);
    case ($urandom_range(0, 4))
      0: q = q[0:$urandom_range(0, q.size() - 1)];
      1: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
      2: repeat (10) q.push_back(8'hFF);
      3: q.push_back({1'b0, 4'($urandom_range(0, 15)), 1'b1, 2'b11});
      default: begin
        q = {};
        repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
      end
    endcase
  endfunction

  // Sends one message, last byte flagged.
  task automatic send_msg(ref bit [7:0] q[$]);
    if (q.size() == 0) q.push_back(8'h00);
    foreach (q[i]) begin
      while (idle_on && $urandom_range(0, 99) < 12) begin
        in_tvalid <= 0;
        @(posedge clk);
      end
      in_tvalid <= 1;
      in_tdata <= q[i];
      in_tlast <= (i == q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bytes_sent++;
    end
    in_tvalid <= 0;
    q = {};
  endtask

  // Drains the block, then writes one register.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [FnW-1:0] val);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [FnW-1:0] a, logic [FnW-1:0] i, logic [FnW-1:0] b,
                           logic [FnW-1:0] r);
    write_reg(CFG_AUDIO_FRAME, a);
    write_reg(CFG_INTERRUPT, i);
    write_reg(CFG_AUDIO_BYTES, b);
    write_reg(CFG_RATE, r);
  endtask

  task automatic random_phase(int unsigned byte_goal);
    int unsigned stop;
    stop = bytes_sent + byte_goal;
    while (bytes_sent < stop) begin
      build_frame(msg);
      if ($urandom_range(0, 99) < 20) break_frame(msg);
      send_msg(msg);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: audio, rate and interrupt in one message with reset registers.
    msg = '{8'h12, 8'h07, 8'h1A, 8'h02, 8'hAA, 8'h55, 8'h20, 8'h80, 8'h7D,
            8'h2A, 8'h00};
    send_msg(msg);
    // Truncated tag, varint, length and fixed field.
    msg = '{8'h88};
    send_msg(msg);
    msg = '{8'h08, 8'hFF};
    send_msg(msg);
    msg = '{8'h0A, 8'h03, 8'h01};
    send_msg(msg);
    msg = '{8'h0D, 8'h01, 8'h02};
    send_msg(msg);
    // Bad wire types.
    msg = '{8'h0B};
    send_msg(msg);
    msg = '{8'h0C};
    send_msg(msg);
    msg = '{8'h0E};
    send_msg(msg);
    msg = '{8'h0F};
    send_msg(msg);
    // Overlong varint, and a ten-byte varint whose last byte sets bit 63.
    repeat (10) msg.push_back(8'hFF);
    send_msg(msg);
    msg = '{8'h08, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01};
    send_msg(msg);
    // Wide field number that would alias the audio frame field in 29 bits.
    put_varint(msg, (64'd1 << 32) | (2 << 3) | WtLen);
    msg = {msg, 8'h00};
    send_msg(msg);
    // Outer length past the frame limit; inner length past the outer remainder.
    msg = '{8'h0A, 8'hFF, 8'hFF, 8'h07, 8'h00};
    send_msg(msg);
    msg = '{8'h12, 8'h02, 8'h1A, 8'h05};
    send_msg(msg);
    // Inner fixed fields, one too large for the outer remainder.
    msg = '{8'h12, 8'h05, 8'h0D, 8'h01, 8'h02, 8'h03, 8'h04};
    send_msg(msg);
    msg = '{8'h12, 8'h03, 8'h09, 8'h00, 8'h00};
    send_msg(msg);
    // Nested message ending inside an inner tag; empty nested message; later audio wins.
    msg = '{8'h12, 8'h01, 8'h98};
    send_msg(msg);
    msg = '{8'h12, 8'h00, 8'h12, 8'h02, 8'h1A, 8'h00, 8'h12, 8'h03, 8'h1A, 8'h01, 8'h33};
    send_msg(msg);

    // Random phases across register settings, one without idling.
    random_phase(400);
    write_all(1, FnMax, FnMax, 1);
    idle_on = 0;
    random_phase(300);
    idle_on = 1;
    write_all(FnMax, 1, 1, FnMax);
    random_phase(300);
    write_all(7, 7, 9, 9);
    random_phase(300);
    write_all(FnW'($urandom_range(1, FnMax)), FnW'($urandom_range(1, 30)),
              FnW'($urandom_range(1, FnMax)), FnW'($urandom_range(1, 30)));
    random_phase(300);
    write_all(2, 5, 3, 4);
    random_phase(200);

    while (sb.due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
